>>> rtl/sjq_pkg.sv
// ----------------------------------------------------------------------------
// sjq_pkg
// Types, codes and constants shared by the scan job queue modules.
// ----------------------------------------------------------------------------
package sjq_pkg;

	localparam int QUEUE_DEPTH_DEF    = 16;
	localparam int MAX_REQUESTERS_DEF = 32;
	localparam int MASK_W             = 32;

	localparam logic [2:0] OP_ADD_NODE  = 3'd0;
	localparam logic [2:0] OP_ADD_TABLE = 3'd1;
	localparam logic [2:0] OP_CANCEL    = 3'd2;
	localparam logic [2:0] OP_START     = 3'd3;
	localparam logic [2:0] OP_NEXT      = 3'd4;
	localparam logic [2:0] OP_STOP      = 3'd5;

	localparam logic [1:0] MODE_ACTIVE  = 2'd0;
	localparam logic [1:0] MODE_PASSIVE = 2'd1;
	localparam logic [1:0] MODE_TABLE   = 2'd2;

	localparam logic [12:0] FREQ_5G_MIN = 13'd3000;
	localparam logic [7:0]  CLASS_2G    = 8'd81;

	localparam logic [2:0] C_HOLD    = 3'd0;
	localparam logic [2:0] C_CLEAR   = 3'd1;
	localparam logic [2:0] C_PUSH    = 3'd2;
	localparam logic [2:0] C_MERGE   = 3'd3;
	localparam logic [2:0] C_CANCEL  = 3'd4;
	localparam logic [2:0] C_POP     = 3'd5;
	localparam logic [2:0] C_COMPACT = 3'd6;

	typedef struct packed {
		logic              valid;
		logic [1:0]        mode;
		logic [7:0]        chan_class;
		logic [7:0]        channel;
		logic [MASK_W-1:0] sources;
	} sjq_entry_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [1:0]        mode;
		logic [7:0]        chan_class;
		logic [7:0]        channel;
		logic [MASK_W-1:0] bit_mask;
	} sjq_ctrl_t;

	function automatic logic [7:0] class_of_channel(input logic [7:0] ch);
		if (ch <= 8'd48)       return 8'd115;
		else if (ch <= 8'd64)  return 8'd118;
		else if (ch <= 8'd144) return 8'd121;
		else                   return 8'd125;
	endfunction

endpackage

>>> rtl/scan_job_queue_engine_top.sv
// ----------------------------------------------------------------------------
// scan_job_queue_engine_top
// Newest-first scan job queue built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Each item passes from acceptance to result in order: the operation is
// applied to every cell, the cell chain closes up gaps one position per cycle,
// and a final step settles scan state and raises the result valid. One item is
// in work at a time; the next is taken once the result has been collected.
module scan_job_queue_engine_top import sjq_pkg::*; #(
	parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
	parameter int MAX_REQUESTERS = MAX_REQUESTERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [31:0] now_time,
	input  logic [12:0] freq_mhz,
	input  logic [7:0]  chan_number,
	input  logic [4:0]  requester_id,
	input  logic        can_active,
	input  logic        can_passive,
	input  logic        can_table,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic        trigger_valid,
	output logic [1:0]  trigger_mode,
	output logic [7:0]  trigger_op_class,
	output logic [7:0]  trigger_channel,
	output logic [31:0] notify_mask,
	output logic        scanning,
	output logic        queue_empty
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH);
	localparam logic [1:0] S_IDLE = 2'd0, S_EXEC = 2'd1, S_COMP = 2'd2, S_FIN = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [2:0]       op_q;
	logic [31:0]      now_q;
	logic [12:0]      freq_q;
	logic [7:0]       ch_q;
	logic [4:0]       rid_q;
	logic             ca_q, cp_q, ct_q;
	logic [31:0]      cooldown_q, end_time_q;
	logic             running_q;
	logic             acc_q, tv_q;
	logic [1:0]       tm_q;
	logic [7:0]       toc_q, tch_q;
	logic [31:0]      notify_q;

	sjq_entry_t cells [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] match;
	sjq_ctrl_t  ctrl;
	sjq_entry_t new_e;
	logic add_ok, rid_ok, any_match, cool, stop_now;
	logic [MASK_W-1:0] or_rest;

	assign in_ready = state_q == S_IDLE && !out_valid_q;
	assign rid_ok   = {1'b0, rid_q} < 6'(MAX_REQUESTERS);
	assign any_match = |match;
	assign cool     = end_time_q != 32'd0 && (now_q - end_time_q) < cooldown_q;

	always_comb begin
		ctrl.mode       = MODE_TABLE;
		ctrl.chan_class = 8'd0;
		ctrl.channel    = 8'd0;
		ctrl.bit_mask   = MASK_W'(1) << rid_q;
		add_ok          = 1'b0;
		if (op_q == OP_ADD_NODE) begin
			ctrl.channel = ch_q;
			if (freq_q < FREQ_5G_MIN) begin
				ctrl.chan_class = CLASS_2G;
				ctrl.mode       = ca_q ? MODE_ACTIVE : MODE_PASSIVE;
				add_ok          = rid_ok && (ca_q || cp_q);
			end else begin
				ctrl.chan_class = class_of_channel(ch_q);
				ctrl.mode       = MODE_PASSIVE;
				add_ok          = rid_ok && cp_q;
			end
		end else begin
			add_ok = rid_ok && ct_q;
		end
		new_e.valid      = 1'b1;
		new_e.mode       = ctrl.mode;
		new_e.chan_class = ctrl.chan_class;
		new_e.channel    = ctrl.channel;
		new_e.sources    = ctrl.bit_mask;
		stop_now = 1'b0;
		ctrl.op  = C_HOLD;
		unique case (state_q)
			S_EXEC: begin
				case (op_q)
					OP_ADD_NODE, OP_ADD_TABLE: begin
						if (add_ok && any_match) ctrl.op = C_MERGE;
						else if (add_ok && !cells[QUEUE_DEPTH-1].valid) ctrl.op = C_PUSH;
					end
					OP_CANCEL: if (rid_ok) ctrl.op = C_CANCEL;
					OP_NEXT: begin
						if (cells[0].valid) ctrl.op = C_POP;
						else begin
							ctrl.op  = C_CLEAR;
							stop_now = 1'b1;
						end
					end
					OP_STOP: begin
						ctrl.op  = C_CLEAR;
						stop_now = 1'b1;
					end
					default: ;
				endcase
			end
			S_COMP: ctrl.op = C_COMPACT;
			S_FIN: begin
				if (op_q == OP_NEXT && !cells[0].valid) begin
					ctrl.op  = C_CLEAR;
					stop_now = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		or_rest = '0;
		for (int j = 1; j < QUEUE_DEPTH; j++)
			if (cells[j].valid) or_rest = or_rest | cells[j].sources;
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		sjq_entry_t pe, ne;
		logic pv;
		if (i == 0) begin : g_head
			assign pe = new_e;
			assign pv = 1'b1;
		end else begin : g_body
			assign pe = cells[i-1];
			assign pv = cells[i-1].valid;
		end
		if (i == QUEUE_DEPTH-1) begin : g_tail
			assign ne = '0;
		end else begin : g_mid
			assign ne = cells[i+1];
		end
		sjq_cell #(.IS_HEAD(i == 0)) u_cell (
			.clk, .arst_n, .ctrl,
			.prev_e(pe), .prev_valid(pv), .next_e(ne),
			.e(cells[i]), .match(match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			cooldown_q  <= '0;
			end_time_q  <= '0;
			running_q   <= 1'b0;
		end else begin
			if (cfg_we) cooldown_q <= cfg_wdata;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (stop_now && running_q) begin
				running_q  <= 1'b0;
				end_time_q <= now_q;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q    <= operation;
						now_q   <= now_time;
						freq_q  <= freq_mhz;
						ch_q    <= chan_number;
						rid_q   <= requester_id;
						ca_q    <= can_active;
						cp_q    <= can_passive;
						ct_q    <= can_table;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					acc_q    <= 1'b0;
					tv_q     <= 1'b0;
					tm_q     <= '0;
					toc_q    <= '0;
					tch_q    <= '0;
					notify_q <= '0;
					case (op_q)
						OP_ADD_NODE, OP_ADD_TABLE:
							acc_q <= add_ok && (any_match || !cells[QUEUE_DEPTH-1].valid);
						OP_START: begin
							if (running_q) acc_q <= 1'b1;
							else if (!cool && cells[0].valid) begin
								running_q  <= 1'b1;
								end_time_q <= '0;
								acc_q      <= 1'b1;
							end
						end
						OP_NEXT: begin
							if (cells[0].valid) begin
								tv_q     <= 1'b1;
								tm_q     <= cells[0].mode;
								toc_q    <= cells[0].chan_class;
								tch_q    <= cells[0].channel;
								notify_q <= cells[0].sources & ~or_rest;
							end
						end
						default: ;
					endcase
					cnt_q   <= '0;
					state_q <= S_COMP;
				end
				S_COMP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUEUE_DEPTH-2)) state_q <= S_FIN;
				end
				S_FIN: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign accepted         = acc_q;
	assign trigger_valid    = tv_q;
	assign trigger_mode     = tm_q;
	assign trigger_op_class = toc_q;
	assign trigger_channel  = tch_q;
	assign notify_mask      = notify_q;
	assign scanning         = running_q;
	assign queue_empty      = !cells[0].valid;

endmodule

>>> rtl/sjq_cell.sv
// ----------------------------------------------------------------------------
// sjq_cell
// One queue slot; shifts, merges, cancels and compacts with its neighbours, and clears or pops.
// ----------------------------------------------------------------------------
module sjq_cell import sjq_pkg::*; #(
	parameter bit IS_HEAD = 1'b0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  sjq_ctrl_t  ctrl,
	input  sjq_entry_t prev_e,
	input  logic       prev_valid,
	input  sjq_entry_t next_e,
	output sjq_entry_t e,
	output logic       match
);

	sjq_entry_t e_q;
	logic [MASK_W-1:0] cleared;

	assign e       = e_q;
	assign cleared = e_q.sources & ~ctrl.bit_mask;
	assign match   = e_q.valid && e_q.mode == ctrl.mode &&
	                 e_q.chan_class == ctrl.chan_class && e_q.channel == ctrl.channel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
		end else begin
			case (ctrl.op)
				C_CLEAR: e_q.valid <= 1'b0;
				C_PUSH:  e_q <= prev_e;
				C_MERGE: begin
					if (match) e_q.sources <= e_q.sources | ctrl.bit_mask;
				end
				C_CANCEL: begin
					if (e_q.valid) begin
						e_q.sources <= cleared;
						e_q.valid   <= |cleared;
					end
				end
				C_POP: begin
					if (IS_HEAD) e_q.valid <= 1'b0;
				end
				C_COMPACT: begin
					if (!e_q.valid && next_e.valid) e_q <= next_e;
					else if (e_q.valid && !prev_valid) e_q.valid <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/sjq_checker.sv
// ----------------------------------------------------------------------------
// sjq_checker
// Port-level checks on the scan job queue engine, bound to the top level.
// ----------------------------------------------------------------------------
module sjq_checker import sjq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        accepted,
	input logic        trigger_valid,
	input logic [1:0]  trigger_mode,
	input logic [31:0] notify_mask
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before taken");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");

	a_acc_trig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(accepted && trigger_valid))
		else $error("accepted and trigger together");

	a_notify: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && notify_mask != 32'd0 |-> trigger_valid && trigger_mode != 2'd3)
		else $error("notify without trigger");

endmodule

bind scan_job_queue_engine_top sjq_checker u_sjq_checker (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready,
	.accepted, .trigger_valid, .trigger_mode, .notify_mask
);

>>> tb/sv/tb_scan_job_queue_engine_top.sv
// ----------------------------------------------------------------------------
// tb_scan_job_queue_engine_top
// Self-checking bench for the scan job queue engine. A local model of the
// job queue and scan state predicts one result per item; a monitor compares
// every result field by field. Directed tests cover an empty queue, the add
// derivation, merging, a full queue, cancel, cool-down and stop, then random
// job sequences run under several cool-down settings with random stalls.
// ----------------------------------------------------------------------------
module tb_scan_job_queue_engine_top;
	import sjq_pkg::*;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RAND_ITEMS = 1250;

	typedef struct packed {
		logic        acc;
		logic        tv;
		logic [1:0]  tm;
		logic [7:0]  toc;
		logic [7:0]  tch;
		logic [31:0] notify;
		logic        scan;
		logic        qe;
	} scan_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  operation = '0;
	logic [31:0] now_time = '0;
	logic [12:0] freq_mhz = '0;
	logic [7:0]  chan_number = '0;
	logic [4:0]  requester_id = '0;
	logic        can_active = 1'b0;
	logic        can_passive = 1'b0;
	logic        can_table = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        accepted, trigger_valid, scanning, queue_empty;
	logic [1:0]  trigger_mode;
	logic [7:0]  trigger_op_class, trigger_channel;
	logic [31:0] notify_mask;

	scan_job_queue_engine_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.now_time(now_time), .freq_mhz(freq_mhz), .chan_number(chan_number),
		.requester_id(requester_id), .can_active(can_active),
		.can_passive(can_passive), .can_table(can_table),
		.out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
		.trigger_valid(trigger_valid), .trigger_mode(trigger_mode),
		.trigger_op_class(trigger_op_class), .trigger_channel(trigger_channel),
		.notify_mask(notify_mask), .scanning(scanning), .queue_empty(queue_empty)
	);

	always #5 clk = ~clk;

	// model of the job queue
	logic        job_valid [DEPTH];
	logic [1:0]  job_mode [DEPTH];
	logic [7:0]  job_class [DEPTH];
	logic [7:0]  job_chan [DEPTH];
	logic [31:0] job_reqs [DEPTH];
	int          job_rank [DEPTH];
	logic        scan_on;
	logic [31:0] scan_ended_at;
	logic [31:0] cooldown;

	scan_result_t pending_results[$];
	int  errors = 0;
	int  cycles = 0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  triggers_seen = 0;
	bit  quiet = 0;
	bit  rx_hold_req = 0;
	logic [31:0] tnow = 32'd1;

	function automatic bit jobs_empty();
		for (int i = 0; i < DEPTH; i++)
			if (job_valid[i]) return 0;
		return 1;
	endfunction

	function automatic void drop_job(int k);
		int r;
		r = job_rank[k];
		job_valid[k] = 0;
		for (int i = 0; i < DEPTH; i++)
			if (job_valid[i] && job_rank[i] > r) job_rank[i]--;
	endfunction

	function automatic bit push_job(logic [1:0] m, logic [7:0] c, logic [7:0] ch,
			logic [31:0] b);
		int fs;
		fs = -1;
		for (int i = 0; i < DEPTH; i++) begin
			if (job_valid[i]) begin
				if (job_mode[i] == m && job_class[i] == c && job_chan[i] == ch) begin
					job_reqs[i] |= b;
					return 1;
				end
			end else if (fs < 0) begin
				fs = i;
			end
		end
		if (fs < 0) return 0;
		for (int i = 0; i < DEPTH; i++)
			if (job_valid[i]) job_rank[i]++;
		job_valid[fs] = 1;
		job_mode[fs] = m;
		job_class[fs] = c;
		job_chan[fs] = ch;
		job_reqs[fs] = b;
		job_rank[fs] = 0;
		return 1;
	endfunction

	function automatic void stop_scan(logic [31:0] now);
		for (int i = 0; i < DEPTH; i++) job_valid[i] = 0;
		if (scan_on) begin
			scan_on = 0;
			scan_ended_at = now;
		end
	endfunction

	function automatic logic [7:0] band_class(logic [7:0] ch);
		if (ch <= 8'd48) return 8'd115;
		if (ch <= 8'd64) return 8'd118;
		if (ch <= 8'd144) return 8'd121;
		return 8'd125;
	endfunction

	function automatic scan_result_t predict_step(logic [2:0] op, logic [31:0] now,
			logic [12:0] freq, logic [7:0] ch, logic [4:0] rid, logic ca, logic cp,
			logic ct);
		scan_result_t r;
		logic [31:0] b;
		int head;
		r = '0;
		b = 32'd1 << rid;
		head = -1;
		case (op)
			OP_ADD_NODE: begin
				if (freq < FREQ_5G_MIN) begin
					if (ca) r.acc = push_job(MODE_ACTIVE, CLASS_2G, ch, b);
					else if (cp) r.acc = push_job(MODE_PASSIVE, CLASS_2G, ch, b);
				end else if (cp) begin
					r.acc = push_job(MODE_PASSIVE, band_class(ch), ch, b);
				end
			end
			OP_ADD_TABLE: if (ct) r.acc = push_job(MODE_TABLE, 8'd0, 8'd0, b);
			OP_CANCEL: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (job_valid[i]) begin
						job_reqs[i] &= ~b;
						if (job_reqs[i] == 0) drop_job(i);
					end
				end
			end
			OP_START: begin
				if (scan_on) begin
					r.acc = 1;
				end else if (!(scan_ended_at != 0 && (now - scan_ended_at) < cooldown)
						&& !jobs_empty()) begin
					scan_on = 1;
					scan_ended_at = 0;
					r.acc = 1;
				end
			end
			OP_NEXT: begin
				for (int i = 0; i < DEPTH; i++)
					if (head < 0 && job_valid[i] && job_rank[i] == 0) head = i;
				if (head < 0) begin
					stop_scan(now);
				end else begin
					r.tv = 1;
					r.tm = job_mode[head];
					r.toc = job_class[head];
					r.tch = job_chan[head];
					r.notify = job_reqs[head];
					drop_job(head);
					for (int i = 0; i < DEPTH; i++)
						if (job_valid[i]) r.notify &= ~job_reqs[i];
					if (jobs_empty()) stop_scan(now);
				end
			end
			OP_STOP: stop_scan(now);
			default: ;
		endcase
		r.scan = scan_on;
		r.qe = jobs_empty();
		return r;
	endfunction

	// sender: valid held until accepted, dropped after, gaps between items
	task automatic send_item(logic [2:0] op, logic [31:0] now, logic [12:0] freq,
			logic [7:0] ch, logic [4:0] rid, logic ca, logic cp, logic ct);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		now_time <= now;
		freq_mhz <= freq;
		chan_number <= ch;
		requester_id <= rid;
		can_active <= ca;
		can_passive <= cp;
		can_table <= ct;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_step(op, now, freq, ch, rid, ca, cp, ct));
		items_sent++;
		@(negedge clk) in_valid <= 1'b0;
	endtask

	task automatic wait_results();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_cooldown(logic [31:0] v);
		wait_results();
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk) cfg_we <= 1'b0;
		cooldown = v;
	endtask

	function automatic logic [31:0] tick();
		tnow = tnow + $urandom_range(1, 40);
		return tnow;
	endfunction

	// receiver
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				rx_hold_req = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		scan_result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (trigger_valid) triggers_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result item");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (accepted !== e.acc) begin
					$error("accepted: exp %0d got %0d", e.acc, accepted); errors++;
				end
				if (trigger_valid !== e.tv) begin
					$error("trigger_valid: exp %0d got %0d", e.tv, trigger_valid); errors++;
				end
				if (trigger_mode !== e.tm) begin
					$error("trigger_mode: exp %0d got %0d", e.tm, trigger_mode); errors++;
				end
				if (trigger_op_class !== e.toc) begin
					$error("trigger_op_class: exp %0d got %0d", e.toc, trigger_op_class);
					errors++;
				end
				if (trigger_channel !== e.tch) begin
					$error("trigger_channel: exp %0d got %0d", e.tch, trigger_channel);
					errors++;
				end
				if (notify_mask !== e.notify) begin
					$error("notify_mask: exp %h got %h", e.notify, notify_mask); errors++;
				end
				if (scanning !== e.scan) begin
					$error("scanning: exp %0d got %0d", e.scan, scanning); errors++;
				end
				if (queue_empty !== e.qe) begin
					$error("queue_empty: exp %0d got %0d", e.qe, queue_empty); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_scan_job_queue_engine_top: done, errors");
			$finish;
		end
	end

	task automatic test_empty_queue();
		send_item(OP_NEXT, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
		send_item(OP_START, tick(), 13'd0, 8'd0, 5'd0, 1'b1, 1'b1, 1'b1);
		send_item(3'd6, tick(), 13'h1FFF, 8'hFF, 5'd31, 1'b1, 1'b1, 1'b1);
		send_item(3'd7, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic test_add_rules();
		send_item(OP_ADD_NODE, tick(), 13'd2999, 8'd1, 5'd0, 1'b1, 1'b1, 1'b0);
		send_item(OP_ADD_NODE, tick(), 13'd0, 8'd6, 5'd1, 1'b0, 1'b1, 1'b0);
		send_item(OP_ADD_NODE, tick(), 13'd100, 8'd7, 5'd2, 1'b0, 1'b0, 1'b1);
		send_item(OP_ADD_NODE, tick(), 13'd3000, 8'd48, 5'd3, 1'b1, 1'b1, 1'b0);
		send_item(OP_ADD_NODE, tick(), 13'd5000, 8'd64, 5'd4, 1'b0, 1'b1, 1'b0);
		send_item(OP_ADD_NODE, tick(), 13'd5500, 8'd144, 5'd5, 1'b0, 1'b1, 1'b0);
		send_item(OP_ADD_NODE, tick(), 13'd7125, 8'd255, 5'd31, 1'b0, 1'b1, 1'b0);
		send_item(OP_ADD_NODE, tick(), 13'd5200, 8'd36, 5'd6, 1'b1, 1'b0, 1'b1);
		send_item(OP_ADD_TABLE, tick(), 13'd0, 8'd9, 5'd7, 1'b0, 1'b0, 1'b1);
		send_item(OP_ADD_TABLE, tick(), 13'd0, 8'd9, 5'd8, 1'b0, 1'b0, 1'b0);
		send_item(OP_ADD_NODE, tick(), 13'd2999, 8'd1, 5'd9, 1'b1, 1'b0, 1'b0);
		send_item(OP_CANCEL, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
		send_item(OP_START, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
		send_item(OP_START, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
		send_item(OP_NEXT, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
		send_item(OP_NEXT, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
		send_item(OP_STOP, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic test_full_queue();
		for (int i = 0; i < DEPTH + 1; i++)
			send_item(OP_ADD_NODE, tick(), 13'd2412, 8'(i * 3), 5'(i), 1'b1, 1'b0, 1'b0);
		send_item(OP_STOP, 32'd0, 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic test_cooldown();
		set_cooldown(32'hFFFF_FFFF);
		send_item(OP_ADD_NODE, tick(), 13'd2412, 8'd1, 5'd0, 1'b1, 1'b0, 1'b0);
		send_item(OP_START, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
		send_item(OP_NEXT, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
		send_item(OP_ADD_NODE, tick(), 13'd2412, 8'd1, 5'd0, 1'b1, 1'b0, 1'b0);
		send_item(OP_START, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
		send_item(OP_STOP, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic rand_add();
		logic [12:0] f;
		logic [7:0] ch;
		case ($urandom_range(0, 5))
			0: f = 13'd2999;
			1: f = 13'd3000;
			2: f = 13'($urandom_range(0, 2999));
			default: f = 13'($urandom_range(0, 7125));
		endcase
		ch = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'(16 * $urandom_range(0, 15));
		send_item($urandom_range(0, 4) == 0 ? OP_ADD_TABLE : OP_ADD_NODE, tick(), f, ch,
			5'($urandom_range(0, 31)), $urandom_range(0, 3) != 0,
			$urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
	endtask

	task automatic rand_item();
		send_item(3'($urandom_range(0, 7)), $urandom_range(0, 7) == 0 ? $urandom : tick(),
			13'($urandom_range(0, 7125)), 8'($urandom), 5'($urandom), 1'($urandom),
			1'($urandom), 1'($urandom));
	endtask

	task automatic scan_sequence();
		int n;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
		repeat (n) rand_add();
		send_item(OP_START, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
		repeat ($urandom_range(1, n + 1)) begin
			if ($urandom_range(0, 5) == 0)
				send_item(OP_CANCEL, tick(), 13'd0, 8'd0, 5'($urandom_range(0, 31)),
					1'b0, 1'b0, 1'b0);
			send_item(OP_NEXT, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
		end
		if ($urandom_range(0, 2) == 0)
			send_item(OP_STOP, tick(), 13'd0, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic test_random();
		logic [31:0] cds [4];
		int stop_at;
		cds[0] = 32'd0;
		cds[1] = 32'd60;
		cds[2] = $urandom_range(1, 400);
		cds[3] = 32'hFFFF_FFFF;
		for (int p = 0; p < 5; p++) begin
			set_cooldown(cds[p % 4]);
			if (p == 4) quiet = 1;
			if (p == 1) rx_hold_req = 1;
			stop_at = items_sent + RAND_ITEMS / 5;
			while (items_sent < stop_at) begin
				if ($urandom_range(0, 9) < 7) scan_sequence();
				else rand_item();
			end
			if (p == 2) wait_results();
		end
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++) job_valid[i] = 0;
		scan_on = 0;
		scan_ended_at = 0;
		cooldown = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_empty_queue();
		test_add_rules();
		test_full_queue();
		test_cooldown();
		test_random();
		wait_results();
		@(negedge clk) in_valid <= 1'b0;
		repeat (40) @(posedge clk);
		$display("%0d items sent, %0d results checked, %0d triggers", items_sent,
			results_seen, triggers_seen);
		$display("covered add rules, merge, full queue, cancel, cool-down, stall");
		if (errors == 0 && pending_results.size() == 0)
			$display("tb_scan_job_queue_engine_top: done, clean");
		else
			$display("tb_scan_job_queue_engine_top: done, errors");
		$finish;
	end

endmodule
